// File: hdl/jse_pkg.sv
package jse_pkg;

    // One queued job: the result bytes that one input item causes.
    typedef struct packed {
        logic [5:0][7:0] data;
        logic [2:0]      len;
        logic            err;
        logic            last;
    } cmd_t;

endpackage

// File: hdl/jse_front.sv
module jse_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  logic [7:0]      in_byte,
    input  logic            string_last,
    output logic            push,
    output jse_pkg::cmd_t   push_cmd,
    input  logic            q_full
);

    typedef enum logic [2:0] {
        CLS_ANY  = 3'd0,
        CLS_A0BF = 3'd1,
        CLS_809F = 3'd2,
        CLS_90BF = 3'd3,
        CLS_808F = 3'd4
    } cls_t;

    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_B        = 8'h62;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_A        = 8'h41;

    logic [7:0] pend_reg [3];
    logic [1:0] cnt_reg,  cnt_next;
    logic [1:0] left_reg, left_next;
    cls_t       cls_reg,  cls_next;
    logic       disc_reg, disc_next;

    logic       fire;
    logic       emit;
    logic       err_c;
    logic       pend_we;
    logic [1:0] pend_idx;
    logic [7:0] esc;
    jse_pkg::cmd_t cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            hex_char = CH_ZERO + {4'd0, v};
        end
        else
        begin
            hex_char = CH_A + {4'd0, v} - 8'd10;
        end
    endfunction

    function automatic logic cont_ok(input logic [7:0] b, input cls_t cls);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        case (cls)
            CLS_A0BF: lo = 8'hA0;
            CLS_809F: hi = 8'h9F;
            CLS_90BF: lo = 8'h90;
            CLS_808F: hi = 8'h8F;
            default:  lo = 8'h80;
        endcase
        cont_ok = (b >= lo) && (b <= hi);
    endfunction

    assign fire       = byte_valid && !q_full;
    assign byte_stall = q_full;
    assign push       = fire && emit;
    assign push_cmd   = cmd;

    always_comb
    begin
        cnt_next  = cnt_reg;
        left_next = left_reg;
        cls_next  = cls_reg;
        disc_next = disc_reg;
        pend_we   = 1'b0;
        pend_idx  = cnt_reg;
        emit      = 1'b0;
        err_c     = 1'b0;
        esc       = 8'h00;
        cmd       = '0;
        cmd.len   = 3'd1;
        cmd.last  = string_last;

        if (disc_reg)
        begin
            if (string_last)
            begin
                disc_next = 1'b0;
            end
        end
        else if (left_reg != 2'd0)
        begin
            if (!cont_ok(in_byte, cls_reg))
            begin
                err_c = 1'b1;
            end
            else if (left_reg == 2'd1)
            begin
                emit         = 1'b1;
                cmd.data[0]  = pend_reg[0];
                cmd.data[1]  = (cnt_reg > 2'd1) ? pend_reg[1] : in_byte;
                cmd.data[2]  = (cnt_reg > 2'd2) ? pend_reg[2] : in_byte;
                cmd.data[3]  = in_byte;
                cmd.len      = {1'b0, cnt_reg} + 3'd1;
                cnt_next     = 2'd0;
                left_next    = 2'd0;
                cls_next     = CLS_ANY;
            end
            else
            begin
                pend_we   = (cnt_reg < 2'd3);
                cnt_next  = (cnt_reg < 2'd3) ? cnt_reg + 2'd1 : cnt_reg;
                left_next = left_reg - 2'd1;
                cls_next  = CLS_ANY;
                err_c     = string_last;
            end
        end
        else if (in_byte < CTRL_LIMIT)
        begin
            emit        = 1'b1;
            cmd.data[0] = CH_BSLASH;
            case (in_byte)
                8'h08:   esc = CH_B;
                8'h09:   esc = CH_T;
                8'h0A:   esc = CH_N;
                8'h0C:   esc = CH_F;
                8'h0D:   esc = CH_R;
                default: esc = 8'h00;
            endcase
            if (esc != 8'h00)
            begin
                cmd.data[1] = esc;
                cmd.len     = 3'd2;
            end
            else
            begin
                cmd.data[1] = CH_U;
                cmd.data[2] = CH_ZERO;
                cmd.data[3] = CH_ZERO;
                cmd.data[4] = hex_char(in_byte[7:4]);
                cmd.data[5] = hex_char(in_byte[3:0]);
                cmd.len     = 3'd6;
            end
        end
        else if (in_byte < ASCII_LIMIT)
        begin
            emit = 1'b1;
            if ((in_byte == CH_QUOTE) || (in_byte == CH_BSLASH))
            begin
                cmd.data[0] = CH_BSLASH;
                cmd.data[1] = in_byte;
                cmd.len     = 3'd2;
            end
            else
            begin
                cmd.data[0] = in_byte;
            end
        end
        else if ((in_byte < 8'hC2) || (in_byte > 8'hF4))
        begin
            err_c = 1'b1;
        end
        else
        begin
            pend_we  = 1'b1;
            pend_idx = 2'd0;
            cnt_next = 2'd1;
            cls_next = CLS_ANY;
            if (in_byte <= 8'hDF)
            begin
                left_next = 2'd1;
            end
            else if (in_byte <= 8'hEF)
            begin
                left_next = 2'd2;
                if (in_byte == 8'hE0)
                begin
                    cls_next = CLS_A0BF;
                end
                else if (in_byte == 8'hED)
                begin
                    cls_next = CLS_809F;
                end
            end
            else
            begin
                left_next = 2'd3;
                if (in_byte == 8'hF0)
                begin
                    cls_next = CLS_90BF;
                end
                else if (in_byte == 8'hF4)
                begin
                    cls_next = CLS_808F;
                end
            end
            err_c = string_last;
        end

        if (err_c)
        begin
            emit      = 1'b1;
            cmd       = '0;
            cmd.len   = 3'd1;
            cmd.err   = 1'b1;
            cmd.last  = 1'b1;
            cnt_next  = 2'd0;
            left_next = 2'd0;
            cls_next  = CLS_ANY;
            disc_next = !string_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            left_reg <= 2'd0;
            cls_reg  <= CLS_ANY;
            disc_reg <= 1'b0;
        end
        else if (fire)
        begin
            cnt_reg  <= cnt_next;
            left_reg <= left_next;
            cls_reg  <= cls_next;
            disc_reg <= disc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && pend_we)
        begin
            pend_reg[pend_idx] <= in_byte;
        end
    end

endmodule

// File: hdl/jse_queue.sv
module jse_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jse_pkg::cmd_t   push_cmd,
    output logic            full,
    output logic            head_valid,
    output jse_pkg::cmd_t   head,
    input  logic            pop
);

    jse_pkg::cmd_t entries_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = entries_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/jse_back.sv
module jse_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  jse_pkg::cmd_t   head,
    output logic            pop,
    output logic            res_valid,
    input  logic            res_stall,
    output logic [7:0]      out_byte,
    output logic            utf8_error,
    output logic            run_last,
    output logic            string_end
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       err_reg;
    logic       rlast_reg;
    logic       send_reg;
    logic       load;
    logic       take;
    logic       at_end;

    assign load   = !valid_reg || !res_stall;
    assign take   = head_valid && load;
    assign at_end = (idx_reg == (head.len - 3'd1));
    assign pop    = take && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = at_end ? 3'd0 : idx_reg + 3'd1;
        end
        valid_next = take ? 1'b1 : (valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg  <= head.data[idx_reg];
            err_reg   <= head.err;
            rlast_reg <= at_end;
            send_reg  <= at_end && head.last;
        end
    end

    assign res_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign utf8_error = err_reg;
    assign run_last   = rlast_reg;
    assign string_end = send_reg;

endmodule

// File: hdl/json_string_escaper.sv
// Channel    Handshake               Payload
// input      byte_valid, byte_stall  in_byte, string_last
// result     res_valid, res_stall    out_byte, utf8_error, run_last, string_end
//
// A byte is accepted every cycle while the two-entry job queue has room.
// An item that causes k results (k is one to six) is sent from the queue head byte by byte,
// so the output register sets the rate: one result per cycle while res_stall is low.
// Held UTF-8 bytes and discarded bytes cause no result.
// Reset clears the decoder state, the queue and the output valid flag at once.
module json_string_escaper
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       utf8_error,
    output logic       run_last,
    output logic       string_end
);

    logic          push;
    logic          q_full;
    logic          head_valid;
    logic          pop;
    jse_pkg::cmd_t push_cmd;
    jse_pkg::cmd_t head;

    jse_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .in_byte     (in_byte),
        .string_last (string_last),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_full      (q_full)
    );

    jse_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    jse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_byte   (out_byte),
        .utf8_error (utf8_error),
        .run_last   (run_last),
        .string_end (string_end)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job queue written while full");

    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && utf8_error) |-> (run_last && string_end && (out_byte == 8'h00)))
        else $error("error result does not close the string");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && string_end) |-> run_last)
        else $error("string end without run end");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job queue read while empty");

endmodule

// File: bench/json_string_escaper_checker.sv
`timescale 1ns / 1ps

module json_string_escaper_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    input  logic       res_valid,
    input  logic       res_stall,
    input  logic [7:0] out_byte,
    input  logic       utf8_error,
    input  logic       run_last,
    input  logic       string_end,
    output int         fail_count,
    output int         expected_left,
    output int         results_seen,
    output int         errors_seen
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [2:0] {
        CLS_ANY,
        CLS_A0_BF,
        CLS_80_9F,
        CLS_90_BF,
        CLS_80_8F
    } cont_range_t;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       run_end;
        logic       str_end;
    } esc_result_t;

    esc_result_t escaped_q[$];

    logic [7:0]  held_bytes [3];
    logic [1:0]  held_count;
    logic [1:0]  cont_left;
    cont_range_t next_range;
    logic        discarding;

    int fails;
    int seen;
    int errs;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
    endfunction

    task automatic push_byte(input logic [7:0] d);
        escaped_q.push_back('{data: d, err: 1'b0, run_end: 1'b0, str_end: 1'b0});
    endtask

    task automatic clear_sequence();
        held_count = 2'd0;
        cont_left  = 2'd0;
        next_range = CLS_ANY;
    endtask

    task automatic push_error(input logic last);
        clear_sequence();
        discarding = !last;
        escaped_q.push_back('{data: 8'h00, err: 1'b1, run_end: 1'b1, str_end: 1'b1});
    endtask

    task automatic predict_escape(input logic [7:0] b, input logic last);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  esc;
        int          i;
        esc_result_t tail;
        if (discarding)
        begin
            if (last)
                discarding = 1'b0;
            return;
        end
        if (cont_left != 2'd0)
        begin
            lo = 8'h80;
            hi = 8'hBF;
            case (next_range)
                CLS_A0_BF: lo = 8'hA0;
                CLS_80_9F: hi = 8'h9F;
                CLS_90_BF: lo = 8'h90;
                CLS_80_8F: hi = 8'h8F;
                default: ;
            endcase
            if (b < lo || b > hi)
            begin
                push_error(last);
                return;
            end
            if (cont_left == 2'd1)
            begin
                for (i = 0; i < held_count; i++)
                    push_byte(held_bytes[i]);
                push_byte(b);
                clear_sequence();
            end
            else
            begin
                held_bytes[held_count] = b;
                held_count = held_count + 2'd1;
                cont_left  = cont_left - 2'd1;
                next_range = CLS_ANY;
                if (last)
                    push_error(last);
                return;
            end
        end
        else if (b < 8'h20)
        begin
            case (b)
                8'h08: esc = "b";
                8'h09: esc = "t";
                8'h0A: esc = "n";
                8'h0C: esc = "f";
                8'h0D: esc = "r";
                default: esc = 8'h00;
            endcase
            push_byte(CH_BSLASH);
            if (esc != 8'h00)
                push_byte(esc);
            else
            begin
                push_byte(CH_U);
                push_byte(CH_ZERO);
                push_byte(CH_ZERO);
                push_byte(hex_digit(b[7:4]));
                push_byte(hex_digit(b[3:0]));
            end
        end
        else if (b < 8'h80)
        begin
            if (b == CH_QUOTE || b == CH_BSLASH)
                push_byte(CH_BSLASH);
            push_byte(b);
        end
        else
        begin
            if (b < 8'hC2 || b > 8'hF4)
            begin
                push_error(last);
                return;
            end
            held_bytes[0] = b;
            held_count = 2'd1;
            next_range = CLS_ANY;
            if (b <= 8'hDF)
                cont_left = 2'd1;
            else if (b <= 8'hEF)
            begin
                cont_left = 2'd2;
                if (b == 8'hE0)
                    next_range = CLS_A0_BF;
                else if (b == 8'hED)
                    next_range = CLS_80_9F;
            end
            else
            begin
                cont_left = 2'd3;
                if (b == 8'hF0)
                    next_range = CLS_90_BF;
                else if (b == 8'hF4)
                    next_range = CLS_80_8F;
            end
            if (last)
                push_error(last);
            return;
        end
        tail = escaped_q.pop_back();
        tail.run_end = 1'b1;
        tail.str_end = last;
        escaped_q.push_back(tail);
    endtask

    task automatic report_mismatch(input esc_result_t want, input logic have_want);
        fails++;
        if (fails <= 10)
        begin
            if (have_want)
                $display("mismatch: expected byte %02h err %0b run_last %0b string_end %0b, got byte %02h err %0b run_last %0b string_end %0b",
                         want.data, want.err, want.run_end, want.str_end,
                         out_byte, utf8_error, run_last, string_end);
            else
                $display("mismatch: unexpected result byte %02h err %0b run_last %0b string_end %0b",
                         out_byte, utf8_error, run_last, string_end);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        esc_result_t want;
        if (!rst_n)
        begin
            escaped_q.delete();
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
            held_bytes[2] = 8'h00;
            clear_sequence();
            discarding = 1'b0;
            fails = 0;
            seen  = 0;
            errs  = 0;
            fail_count    <= 0;
            expected_left <= 0;
            results_seen  <= 0;
            errors_seen   <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                seen++;
                if (utf8_error)
                    errs++;
                if (escaped_q.size() == 0)
                begin
                    want = '0;
                    report_mismatch(want, 1'b0);
                end
                else
                begin
                    want = escaped_q.pop_front();
                    if (out_byte !== want.data || utf8_error !== want.err ||
                        run_last !== want.run_end || string_end !== want.str_end)
                        report_mismatch(want, 1'b1);
                end
            end
            if (byte_valid && !byte_stall)
                predict_escape(in_byte, string_last);
            fail_count    <= fails;
            expected_left <= escaped_q.size();
            results_seen  <= seen;
            errors_seen   <= errs;
        end
    end

endmodule

// File: bench/json_string_escaper_tb.sv
`timescale 1ns / 1ps

module json_string_escaper_tb;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       byte_valid  = 1'b0;
    logic       byte_stall;
    logic [7:0] in_byte     = 8'h00;
    logic       string_last = 1'b0;
    logic       res_valid;
    logic       res_stall   = 1'b0;
    logic [7:0] out_byte;
    logic       utf8_error;
    logic       run_last;
    logic       string_end;

    int fail_count;
    int expected_left;
    int results_seen;
    int errors_seen;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;
    int strings_sent       = 0;

    logic [7:0] str_bytes[$];

    json_string_escaper dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .in_byte     (in_byte),
        .string_last (string_last),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .out_byte    (out_byte),
        .utf8_error  (utf8_error),
        .run_last    (run_last),
        .string_end  (string_end)
    );

    json_string_escaper_checker escape_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .in_byte       (in_byte),
        .string_last   (string_last),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_byte      (out_byte),
        .utf8_error    (utf8_error),
        .run_last      (run_last),
        .string_end    (string_end),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .results_seen  (results_seen),
        .errors_seen   (errors_seen)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still expected", expected_left);
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < receiver_stall_pct);

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid  <= 1'b1;
        in_byte     <= b;
        string_last <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_string();
        int k;
        for (k = 0; k < str_bytes.size(); k++)
            send_byte(str_bytes[k], k == str_bytes.size() - 1);
        strings_sent++;
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
    endtask

    task automatic append_char();
        logic [7:0] lead;
        case ($urandom_range(9))
            0: str_bytes.push_back(8'($urandom_range(31)));
            1:
            begin
                case ($urandom_range(2))
                    0: str_bytes.push_back(8'h22);
                    1: str_bytes.push_back(8'h5C);
                    default: str_bytes.push_back(8'h7F);
                endcase
            end
            2, 3: str_bytes.push_back(8'($urandom_range(32, 127)));
            4, 5:
            begin
                str_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            6, 7:
            begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                str_bytes.push_back(lead);
                if (lead == 8'hE0)
                    str_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                else if (lead == 8'hED)
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                else
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default:
            begin
                lead = 8'($urandom_range(8'hF0, 8'hF4));
                str_bytes.push_back(lead);
                if (lead == 8'hF0)
                    str_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                else if (lead == 8'hF4)
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                else
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endtask

    // Most strings are well formed; the rest are noise, corrupted, or cut off.
    task automatic build_string();
        int n_chars;
        int k;
        int mode;
        str_bytes.delete();
        mode = $urandom_range(99);
        if (mode < 8)
        begin
            n_chars = $urandom_range(1, 6);
            for (k = 0; k < n_chars; k++)
                str_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            n_chars = $urandom_range(1, 8);
            for (k = 0; k < n_chars; k++)
                append_char();
            if (mode < 16)
                str_bytes[$urandom_range(str_bytes.size() - 1)] = 8'($urandom_range(255));
            else if (mode < 22)
                str_bytes.push_back(8'($urandom_range(8'hC2, 8'hF4)));
            else if (mode < 26 && str_bytes.size() > 1)
                void'(str_bytes.pop_back());
        end
    endtask

    initial
    begin
        int phase;
        int phase_start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        str_bytes = '{8'h00, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h1F, 8'h20,
                      8'h22, 8'h5C, 8'h7F};
        send_string();
        str_bytes = '{8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
                      8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        str_bytes = '{8'hC1, 8'hFF};
        send_string();
        str_bytes = '{8'hC3};
        send_string();
        str_bytes = '{8'hE0, 8'h9F, 8'h41};
        send_string();
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 0;
                end
                1:
                begin
                    sender_idle_pct = 88;
                    receiver_stall_pct <= 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 88;
                end
                default:
                begin
                    sender_idle_pct = 35;
                    receiver_stall_pct <= 35;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 95)
            begin
                build_string();
                send_string();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("sent %0d bytes in %0d strings under four idle and stall mixes",
                 items_sent, strings_sent);
        $display("checked %0d escaped results, %0d of them UTF-8 errors",
                 results_seen, errors_seen);
        if (fail_count == 0 && expected_left == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
